### src/iss_pkg.sv
// Shared constants, register map and table lookup helpers for the idle state selector.
package iss_pkg;

  // Default and width of the state index space.
  localparam int unsigned MaxStatesDefault = 4;
  localparam int unsigned TableEntries     = 4;
  localparam int unsigned IdxW             = 4;

  // Input word field widths.
  localparam int unsigned ExpectedW = 22;
  localparam int unsigned LimitW    = 24;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned ElapsedW  = 31;
  localparam int unsigned InDataW   = 128;
  localparam int unsigned OutDataW  = 8;

  // Configuration port geometry.
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;

  // Register indexes.
  localparam logic [2:0] RegStateCount = 3'd0;
  localparam logic [2:0] RegResTable   = 3'd1;
  localparam logic [2:0] RegLatTable   = 3'd2;
  localparam logic [2:0] RegTimeValid  = 3'd3;
  localparam logic [2:0] RegCheckBm    = 3'd4;
  localparam logic [2:0] RegHoldoff    = 3'd5;
  localparam logic [2:0] RegTick       = 3'd6;

  // Register reset values.
  localparam logic [2:0]  StateCountRst = 3'd4;
  localparam logic [3:0]  TimeValidRst  = 4'hF;
  localparam logic [19:0] HoldoffRst    = 20'd20000;
  localparam logic [13:0] TickRst       = 14'd4000;

  // Early-break threshold and saturation limits.
  localparam logic [2:0]          BreakLimit = 3'd5;
  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};
  localparam logic [TimeW-1:0]    TimeMax    = {TimeW{1'b1}};

  // Command codes carried in tuser.
  localparam logic CmdSelect  = 1'b0;
  localparam logic CmdReflect = 1'b1;

  // One 16-bit entry of a packed table; states past the table read zero.
  function automatic logic [15:0] entry16(input logic [63:0] tbl, input logic [IdxW-1:0] i);
    logic [15:0] val;
    val = 16'd0;
    if (i[IdxW-1:2] == '0) begin
      val = tbl[{i[1:0], 4'b0000} +: 16];
    end
    return val;
  endfunction

  // One bit of a per-state mask; states past the mask read zero.
  function automatic logic mask_bit(input logic [3:0] m, input logic [IdxW-1:0] i);
    logic b;
    b = 1'b0;
    if (i[IdxW-1:2] == '0) begin
      b = m[i[1:0]];
    end
    return b;
  endfunction

endpackage

### src/idle_state_selector_core.sv
// Idle state selector: sequencer that caps, walks and reflects over the idle state table.
// A select word passes through the bus-master scan, which looks for the first state that needs
// the bus-master check, the cap step, the residency and latency walk and the done state; a
// reflect word passes through the reflect step and the done state. The scan and the walk each
// look at one state per cycle. The input side is ready only while the sequencer is idle; a
// finished result waits in the output register while the next word is taken, but the sequencer
// holds in its done state while that register still holds an untaken result. Configuration is
// written through the APB port at byte address 8*i and should only change while no word is in
// flight.
module idle_state_selector_core #(
  parameter int unsigned MAX_STATES = iss_pkg::MaxStatesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input words.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // forecast_us[21:0], latency_limit_us[45:22], bm_active[46], now_us[94:47],
  // slept_us[125:95], zero fill[127:126]
  input  logic [iss_pkg::InDataW-1:0]   s_axis_tdata,
  // command[0]
  input  logic                          s_axis_tuser,
  // Result words.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // chosen_state[1:0], max_allowed_state[4:2], demotion_active[5], zero fill[7:6]
  output logic [iss_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iss_pkg::CfgAddrW-1:0]  paddr,
  input  logic [iss_pkg::CfgDataW-1:0]  pwdata,
  output logic [iss_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import iss_pkg::*;

  localparam int unsigned CW = $clog2(MAX_STATES + 1);
  localparam int unsigned NW = (CW > 3) ? CW : 3;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BMSCAN = 3'd1;
  localparam logic [2:0] ST_CAP    = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_REFL   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // Configuration registers.
  logic [2:0]  state_count_q;
  logic [63:0] res_tbl_q;
  logic [63:0] lat_tbl_q;
  logic [3:0]  tv_mask_q;
  logic [3:0]  bm_mask_q;
  logic [19:0] holdoff_q;
  logic [13:0] tick_q;

  // Captured input word.
  logic                cmd_q;
  logic [ExpectedW-1:0] exp_q;
  logic [LimitW-1:0]   lim_q;
  logic                bma_q;
  logic [TimeW-1:0]    now_q;
  logic [ElapsedW-1:0] meas_q;

  // Governor state.
  logic [1:0]          last_state_q, last_state_d;
  logic [1:0]          dem_lim_q, dem_lim_d;
  logic                dem_valid_q, dem_valid_d;
  logic [TimeW-1:0]    dem_exp_q, dem_exp_d;
  logic [2:0]          early_cnt_q, early_cnt_d;
  logic [ElapsedW-1:0] bm_elapsed_q, bm_elapsed_d;

  // Sequencer.
  logic [2:0]    fsm_q, fsm_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cap_q, cap_d;
  logic [5:0]    res_q, res_d;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic [5:0] out_data_q;
  logic       out_load;

  // Datapath helpers.
  logic [NW-1:0]       sc_wide;
  logic [NW-1:0]       n_wide;
  logic [CW-1:0]       n_states;
  logic [IdxW-1:0]     idx_ext;
  logic [15:0]         res_at_idx;
  logic [15:0]         lat_at_idx;
  logic                state_fits;
  logic [ElapsedW-1:0] elapsed_sel;
  logic [CW-1:0]       cap_base;
  logic [NW-1:0]       dem_cap;
  logic [CW-1:0]       walk_pick;
  logic [1:0]          chosen;
  logic [15:0]         res_last;
  logic [ElapsedW-1:0] meas_sel;
  logic [ElapsedW:0]   elapsed_sum;
  logic [TimeW:0]      exp_sum;
  logic [2:0]          addr_idx;
  logic                cfg_wr;

  assign pready   = 1'b1;
  assign addr_idx = paddr[CfgAddrW-1:3];
  assign cfg_wr   = psel & penable & pwrite & pready;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q <= StateCountRst;
      res_tbl_q     <= '0;
      lat_tbl_q     <= '0;
      tv_mask_q     <= TimeValidRst;
      bm_mask_q     <= '0;
      holdoff_q     <= HoldoffRst;
      tick_q        <= TickRst;
    end else if (cfg_wr) begin
      case (addr_idx)
        RegStateCount: state_count_q <= pwdata[2:0];
        RegResTable:   res_tbl_q     <= pwdata;
        RegLatTable:   lat_tbl_q     <= pwdata;
        RegTimeValid:  tv_mask_q     <= pwdata[3:0];
        RegCheckBm:    bm_mask_q     <= pwdata[3:0];
        RegHoldoff:    holdoff_q     <= pwdata[19:0];
        RegTick:       tick_q        <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (addr_idx)
      RegStateCount: prdata = 64'(state_count_q);
      RegResTable:   prdata = res_tbl_q;
      RegLatTable:   prdata = lat_tbl_q;
      RegTimeValid:  prdata = 64'(tv_mask_q);
      RegCheckBm:    prdata = 64'(bm_mask_q);
      RegHoldoff:    prdata = 64'(holdoff_q);
      RegTick:       prdata = 64'(tick_q);
      default:       prdata = '0;
    endcase
  end

  // Number of states in use, with out-of-range counts clamped.
  always_comb begin
    sc_wide = NW'(state_count_q);
    if (sc_wide == '0) begin
      n_wide = NW'(1);
    end else if (sc_wide > NW'(MAX_STATES)) begin
      n_wide = NW'(MAX_STATES);
    end else begin
      n_wide = sc_wide;
    end
    n_states = n_wide[CW-1:0];
  end

  // Shared table compare unit: one state per cycle.
  assign idx_ext    = IdxW'(idx_q);
  assign res_at_idx = entry16(res_tbl_q, idx_ext);
  assign lat_at_idx = entry16(lat_tbl_q, idx_ext);
  assign state_fits = (idx_q < cap_q) && (ExpectedW'(res_at_idx) <= exp_q)
                      && (LimitW'(lat_at_idx) <= lim_q);

  assign s_axis_tready = (fsm_q == ST_IDLE);
  assign out_load      = (fsm_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // Sequencer and governor state update.
  always_comb begin
    fsm_d        = fsm_q;
    idx_d        = idx_q;
    cap_d        = cap_q;
    res_d        = res_q;
    last_state_d = last_state_q;
    dem_lim_d    = dem_lim_q;
    dem_valid_d  = dem_valid_q;
    dem_exp_d    = dem_exp_q;
    early_cnt_d  = early_cnt_q;
    bm_elapsed_d = bm_elapsed_q;
    elapsed_sel  = bm_elapsed_q;
    cap_base     = n_states;
    dem_cap      = NW'(dem_lim_q) + NW'(1);
    walk_pick    = idx_q - CW'(1);
    chosen       = walk_pick[1:0];
    res_last     = entry16(res_tbl_q, IdxW'(last_state_q));
    meas_sel     = mask_bit(tv_mask_q, IdxW'(last_state_q)) ? meas_q : ElapsedW'(tick_q);
    elapsed_sum  = (ElapsedW + 1)'(bm_elapsed_q) + (ElapsedW + 1)'(meas_sel);
    exp_sum      = (TimeW + 1)'(now_q) + (TimeW + 1)'(res_last);

    case (fsm_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          idx_d = CW'(1);
          fsm_d = (s_axis_tuser == CmdReflect) ? ST_REFL : ST_BMSCAN;
        end
      end
      // Find the first state that needs the bus-master check.
      ST_BMSCAN: begin
        if ((idx_q < n_states) && !mask_bit(bm_mask_q, idx_ext)) begin
          idx_d = idx_q + CW'(1);
        end else begin
          cap_d = idx_q;
          fsm_d = ST_CAP;
        end
      end
      // Apply the bus-master holdoff and the timed demotion limit.
      ST_CAP: begin
        if (bma_q) begin
          elapsed_sel = '0;
        end
        bm_elapsed_d = elapsed_sel;
        if (ElapsedW'(holdoff_q) >= elapsed_sel) begin
          cap_base = cap_q;
        end
        cap_d = cap_base;
        if (dem_valid_q) begin
          if (dem_exp_q > now_q) begin
            if (dem_cap < NW'(cap_base)) begin
              cap_d = dem_cap[CW-1:0];
            end
          end else begin
            dem_valid_d = 1'b0;
          end
        end
        idx_d = CW'(1);
        fsm_d = ST_WALK;
      end
      // Walk toward deeper states while residency and latency fit.
      ST_WALK: begin
        if (state_fits) begin
          idx_d = idx_q + CW'(1);
        end else begin
          if (last_state_q != chosen) begin
            early_cnt_d = '0;
          end
          last_state_d = chosen;
          res_d        = {dem_valid_q, 3'(cap_q), chosen};
          fsm_d        = ST_DONE;
        end
      end
      // Account for the residency of the last sleep.
      ST_REFL: begin
        bm_elapsed_d = elapsed_sum[ElapsedW] ? ElapsedMax : elapsed_sum[ElapsedW-1:0];
        if (last_state_q != 2'd0) begin
          if (meas_sel < ElapsedW'(res_last)) begin
            if (early_cnt_q > BreakLimit) begin
              dem_lim_d   = last_state_q - 2'd1;
              dem_valid_d = 1'b1;
              dem_exp_d   = exp_sum[TimeW] ? TimeMax : exp_sum[TimeW-1:0];
            end else begin
              early_cnt_d = early_cnt_q + 3'd1;
            end
          end else if (early_cnt_q != '0) begin
            early_cnt_d = early_cnt_q - 3'd1;
          end
        end
        res_d = {dem_valid_d, 3'd0, last_state_q};
        fsm_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          fsm_d = ST_IDLE;
        end
      end
      default: fsm_d = ST_IDLE;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q        <= ST_IDLE;
      idx_q        <= '0;
      cap_q        <= '0;
      last_state_q <= '0;
      dem_lim_q    <= '0;
      dem_valid_q  <= 1'b0;
      dem_exp_q    <= '0;
      early_cnt_q  <= '0;
      bm_elapsed_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      fsm_q        <= fsm_d;
      idx_q        <= idx_d;
      cap_q        <= cap_d;
      last_state_q <= last_state_d;
      dem_lim_q    <= dem_lim_d;
      dem_valid_q  <= dem_valid_d;
      dem_exp_q    <= dem_exp_d;
      early_cnt_q  <= early_cnt_d;
      bm_elapsed_q <= bm_elapsed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Input word capture and result payload.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q  <= s_axis_tuser;
      exp_q  <= s_axis_tdata[21:0];
      lim_q  <= s_axis_tdata[45:22];
      bma_q  <= s_axis_tdata[46];
      now_q  <= s_axis_tdata[94:47];
      meas_q <= s_axis_tdata[125:95];
    end
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_data_q};

  // The residency update step is entered only for a reflect word.
  a_reflect_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_REFL) |-> (cmd_q == CmdReflect))
    else $error("reflect step entered for a select word");

  // The walk never steps past the cap.
  a_walk_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_WALK) |-> (idx_q <= cap_q))
    else $error("state walk passed the cap");

  // The early-break counter stops one past its limit.
  a_early_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    early_cnt_q <= BreakLimit + 3'd1)
    else $error("early-break counter out of range");

  // Demotion is armed only after enough early breaks.
  a_demote_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dem_valid_q) |-> ($past(early_cnt_q) > BreakLimit))
    else $error("demotion armed without enough early breaks");

  // A pending result is never overwritten before it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pending result overwritten");

endmodule

### tb/sv/idle_state_selector_core_tb.sv
// Self-checking testbench for the idle state selector core, with its own governor predictor.
`timescale 1ns / 1ps

module idle_state_selector_core_tb;
  import iss_pkg::*;

  // One input word as the sender sees it.
  typedef struct packed {
    logic                 cmd;
    logic [ExpectedW-1:0] forecast_us;
    logic [LimitW-1:0]    limit_us;
    logic                 bm_active;
    logic [TimeW-1:0]     now_us;
    logic [ElapsedW-1:0]  slept_us;
  } sleep_req_t;

  // One result word, split into its fields.
  typedef struct packed {
    logic [1:0] state;
    logic [2:0] cap;
    logic       demoted;
  } idle_choice_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Predictor copy of the registers.
  logic [2:0]  cfg_count   = StateCountRst;
  logic [63:0] cfg_res     = '0;
  logic [63:0] cfg_lat     = '0;
  logic [3:0]  cfg_valid   = TimeValidRst;
  logic [3:0]  cfg_bm      = '0;
  logic [19:0] cfg_holdoff = HoldoffRst;
  logic [13:0] cfg_tick    = TickRst;

  // Predictor copy of the governor state.
  logic [1:0]          gov_last_state   = '0;
  logic [1:0]          gov_demote_cap   = '0;
  logic                gov_demote_on    = 1'b0;
  logic [TimeW-1:0]    gov_demote_until = '0;
  logic [2:0]          gov_breaks       = '0;
  logic [ElapsedW-1:0] gov_bm_elapsed   = '0;

  idle_choice_t     choice_q[$];
  int unsigned      fault_count = 0;
  bit               bursty      = 1'b1;
  logic [TimeW-1:0] wall_us     = '0;

  idle_state_selector_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Table entries and mask bits past the four stored states read as zero.
  function automatic logic [15:0] table_field(input logic [63:0] tbl, input int unsigned idx);
    if (idx >= TableEntries) return 16'd0;
    return tbl[16*idx +: 16];
  endfunction

  function automatic logic flag_of(input logic [3:0] m, input int unsigned idx);
    if (idx >= TableEntries) return 1'b0;
    return m[idx];
  endfunction

  // Governor predictor: updates the state copy and returns the result of one word.
  function automatic idle_choice_t predict_idle_choice(input sleep_req_t r);
    idle_choice_t        c;
    int unsigned         n;
    int unsigned         cap;
    int unsigned         deep;
    int unsigned         idx;
    int unsigned         lim_cap;
    logic [15:0]         res;
    logic [ElapsedW-1:0] meas;
    logic [ElapsedW:0]   total;
    logic [TimeW:0]      expiry;
    n = 32'(cfg_count);
    if (n == 0) n = 1;
    if (n > MaxStatesDefault) n = MaxStatesDefault;
    if (r.cmd == CmdSelect) begin
      // Deepest state reachable without a bus-master check.
      deep = 1;
      while (deep < n && !flag_of(cfg_bm, deep)) deep++;
      deep = deep - 1;
      cap = n;
      if (r.bm_active) gov_bm_elapsed = '0;
      if (gov_bm_elapsed <= ElapsedW'(cfg_holdoff)) cap = deep + 1;
      // A timed demotion limits the cap until it runs out.
      if (gov_demote_on) begin
        if (gov_demote_until > r.now_us) begin
          lim_cap = 32'(gov_demote_cap);
          lim_cap = lim_cap + 1;
          if (lim_cap < cap) cap = lim_cap;
        end else begin
          gov_demote_on = 1'b0;
        end
      end
      // Walk to the deepest state whose residency and exit latency fit.
      idx = 1;
      while (idx < cap && ExpectedW'(table_field(cfg_res, idx)) <= r.forecast_us &&
             LimitW'(table_field(cfg_lat, idx)) <= r.limit_us) idx++;
      idx = idx - 1;
      if (gov_last_state != 2'(idx)) gov_breaks = '0;
      gov_last_state = 2'(idx);
      c.cap = 3'(cap);
    end else begin
      res  = table_field(cfg_res, 32'(gov_last_state));
      meas = r.slept_us;
      if (!flag_of(cfg_valid, 32'(gov_last_state))) meas = ElapsedW'(cfg_tick);
      total          = {1'b0, gov_bm_elapsed} + {1'b0, meas};
      gov_bm_elapsed = total[ElapsedW] ? ElapsedMax : total[ElapsedW-1:0];
      // Early wakeups from a deep state count up and eventually arm a demotion.
      if (gov_last_state != 2'd0) begin
        if (meas < ElapsedW'(res)) begin
          if (gov_breaks > BreakLimit) begin
            expiry           = {1'b0, r.now_us} + (TimeW + 1)'(res);
            gov_demote_cap   = gov_last_state - 2'd1;
            gov_demote_on    = 1'b1;
            gov_demote_until = expiry[TimeW] ? TimeMax : expiry[TimeW-1:0];
          end else begin
            gov_breaks = gov_breaks + 3'd1;
          end
        end else if (gov_breaks > 3'd0) begin
          gov_breaks = gov_breaks - 3'd1;
        end
      end
      c.cap = 3'd0;
    end
    c.state   = gov_last_state;
    c.demoted = gov_demote_on;
    return c;
  endfunction

  function automatic sleep_req_t mk_req(input logic cmd, input logic [ExpectedW-1:0] exp_us,
                                        input logic [LimitW-1:0] lim_us, input logic bm,
                                        input logic [TimeW-1:0] now,
                                        input logic [ElapsedW-1:0] meas);
    sleep_req_t r;
    r.cmd         = cmd;
    r.forecast_us = exp_us;
    r.limit_us    = lim_us;
    r.bm_active   = bm;
    r.now_us      = now;
    r.slept_us    = meas;
    return r;
  endfunction

  // The wall clock mostly creeps forward, with rare jumps anywhere and close to the top.
  function automatic logic [TimeW-1:0] next_now();
    case ($urandom_range(0, 39))
      0: begin
        wall_us[47:32] = 16'($urandom);
        wall_us[31:0]  = $urandom;
      end
      1: wall_us = TimeMax - TimeW'($urandom_range(0, 70000));
      default: wall_us = wall_us + TimeW'($urandom_range(0, 2000));
    endcase
    return wall_us;
  endfunction

  // Four residencies or latencies in rising order, as real state tables are laid out.
  function automatic logic [63:0] rising_table();
    logic [15:0] e [4];
    e[0] = 16'($urandom_range(0, 100));
    for (int j = 1; j < 4; j++) e[j] = e[j-1] + 16'($urandom_range(0, 15000));
    return {e[3], e[2], e[1], e[0]};
  endfunction

  function automatic void note_fault(input string msg);
    if (fault_count < 10) $display("MISMATCH at %0t ns: %s", $time, msg);
    fault_count++;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) note_fault($sformatf("%s expected %0d, got %0d", name, want, got));
  endfunction

  // Result checker: every accepted word is compared with the oldest prediction.
  always @(posedge clk_i) begin
    idle_choice_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (choice_q.size() == 0) begin
        note_fault($sformatf("result word %h arrived with nothing expected", m_axis_tdata));
      end else begin
        want = choice_q.pop_front();
        check_field("chosen_state", 8'(want.state), 8'(m_axis_tdata[1:0]));
        check_field("max_allowed_state", 8'(want.cap), 8'(m_axis_tdata[4:2]));
        check_field("demotion_active", 8'(want.demoted), 8'(m_axis_tdata[5]));
      end
    end
  end

  // Receiver: ready, broken by random stalls while bursty traffic is on.
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (bursty && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Sends one word, possibly after an idle gap, and records its prediction on acceptance.
  task automatic offer_word(input sleep_req_t w);
    if (bursty && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.cmd;
    s_axis_tdata  <= {2'b00, w.slept_us, w.now_us, w.bm_active, w.limit_us, w.forecast_us};
    do @(posedge clk_i); while (!s_axis_tready);
    choice_q.push_back(predict_idle_choice(w));
  endtask

  // Stops sending and waits until every predicted word has come back.
  task automatic settle_outstanding();
    s_axis_tvalid <= 1'b0;
    while (choice_q.size() != 0) @(posedge clk_i);
  endtask

  // One register write: setup phase, then access phase held until pready.
  task automatic write_setting(input logic [2:0] idx, input logic [63:0] value);
    case (idx)
      RegStateCount: cfg_count   = value[2:0];
      RegResTable:   cfg_res     = value;
      RegLatTable:   cfg_lat     = value;
      RegTimeValid:  cfg_valid   = value[3:0];
      RegCheckBm:    cfg_bm      = value[3:0];
      RegHoldoff:    cfg_holdoff = value[19:0];
      RegTick:       cfg_tick    = value[13:0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes every register; some kinds pin the extremes, the rest are random.
  task automatic load_setup(input int kind);
    logic [63:0] val [7];
    val[RegStateCount] = 64'($urandom_range(0, 7));
    val[RegResTable]   = rising_table();
    val[RegLatTable]   = rising_table();
    val[RegTimeValid]  = 64'($urandom_range(0, 15));
    val[RegCheckBm]    = 64'($urandom_range(0, 15));
    val[RegHoldoff]    = 64'($urandom_range(0, 20'hFFFFF));
    val[RegTick]       = 64'($urandom_range(0, 14'h3FFF));
    case (kind)
      0: begin
        val[RegStateCount] = 64'd1;
        val[RegResTable]   = '0;
        val[RegLatTable]   = '1;
        val[RegTimeValid]  = 64'd0;
        val[RegCheckBm]    = 64'd0;
        val[RegHoldoff]    = 64'd0;
        val[RegTick]       = 64'd1;
      end
      1: begin
        val[RegStateCount] = 64'd4;
        val[RegTimeValid]  = 64'hF;
        val[RegCheckBm]    = 64'hE;
        val[RegHoldoff]    = 64'd1000000;
        val[RegTick]       = 64'd10000;
      end
      2: begin
        val[RegStateCount] = 64'd0;
        val[RegTick]       = 64'h3FFF;
      end
      3: begin
        val[RegStateCount] = 64'd7;
        val[RegResTable]   = '1;
        val[RegLatTable]   = '0;
        val[RegHoldoff]    = 64'hFFFFF;
      end
      4: begin
        val[RegResTable] = {$urandom, $urandom};
        val[RegLatTable] = {$urandom, $urandom};
      end
      default: ;
    endcase
    for (int r = RegStateCount; r <= RegTick; r++) write_setting(3'(r), val[r]);
  endtask

  // Mostly select/reflect pairs in steady stretches, with lone random words as noise.
  task automatic run_sleep_traffic(input int words);
    int                   sent;
    logic [ExpectedW-1:0] exp_us;
    logic [LimitW-1:0]    lim_us;
    logic [ElapsedW-1:0]  meas;
    sent = 0;
    while (sent < words) begin
      // A steady stretch keeps the same forecast so the chosen state holds.
      if ($urandom_range(0, 3) == 0) begin
        exp_us = ExpectedW'($urandom_range(0, 22'h3FFFFF));
        lim_us = LimitW'($urandom_range(0, 24'hFFFFFF));
      end else begin
        exp_us = ExpectedW'($urandom_range(0, 70000));
        lim_us = LimitW'($urandom_range(0, 70000));
      end
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(0, 9) == 0) begin
          offer_word(mk_req(1'($urandom_range(0, 1)), ExpectedW'($urandom_range(0, 22'h3FFFFF)),
                            LimitW'($urandom_range(0, 24'hFFFFFF)), 1'($urandom_range(0, 1)),
                            next_now(), ElapsedW'($urandom_range(0, 31'h7FFFFFFF))));
          sent++;
        end else begin
          case ($urandom_range(0, 7))
            0: meas = ElapsedW'($urandom_range(0, 31'h7FFFFFFF));
            1: meas = ElapsedMax;
            2: meas = ElapsedW'($urandom_range(20000, 70000));
            default: meas = ElapsedW'($urandom_range(0, 3000));
          endcase
          offer_word(mk_req(CmdSelect, exp_us, lim_us, $urandom_range(0, 3) == 0, next_now(),
                            ElapsedW'($urandom_range(0, 31'h7FFFFFFF))));
          offer_word(mk_req(CmdReflect, ExpectedW'($urandom_range(0, 22'h3FFFFF)),
                            LimitW'($urandom_range(0, 24'hFFFFFF)), 1'($urandom_range(0, 1)),
                            next_now(), meas));
          sent += 2;
        end
      end
    end
  endtask

  // Reset registers: empty tables, field extremes and elapsed-time saturation.
  task automatic test_reset_setup();
    offer_word(mk_req(CmdSelect, '0, '0, 1'b0, '0, '0));
    offer_word(mk_req(CmdReflect, '0, '0, 1'b0, '0, ElapsedMax));
    offer_word(mk_req(CmdReflect, '1, '1, 1'b1, TimeMax, 31'd1));
    offer_word(mk_req(CmdSelect, '1, '1, 1'b1, TimeMax, ElapsedMax));
  endtask

  // Bus-master holdoff caps the search until enough residency has built up.
  task automatic test_bus_master_holdoff();
    settle_outstanding();
    write_setting(RegResTable, {16'd800, 16'd300, 16'd50, 16'd0});
    write_setting(RegLatTable, {16'd400, 16'd100, 16'd20, 16'd0});
    write_setting(RegCheckBm, 64'h4);
    write_setting(RegHoldoff, 64'd1000);
    offer_word(mk_req(CmdSelect, 22'd60000, 24'd60000, 1'b1, 48'd100, '0));
    offer_word(mk_req(CmdReflect, '0, '0, 1'b0, 48'd200, 31'd5000));
    offer_word(mk_req(CmdSelect, 22'd60000, 24'd60000, 1'b0, 48'd300, '0));
    offer_word(mk_req(CmdSelect, 22'd100, 24'd60000, 1'b0, 48'd400, '0));
    offer_word(mk_req(CmdSelect, 22'd1000, 24'd50, 1'b0, 48'd500, '0));
  endtask

  // Repeated early wakeups from an unmeasured state arm a demotion, which then expires.
  task automatic test_break_demotion();
    settle_outstanding();
    write_setting(RegHoldoff, '0);
    write_setting(RegTimeValid, 64'h7);
    write_setting(RegTick, 64'd1);
    for (int k = 0; k < 7; k++) begin
      offer_word(mk_req(CmdSelect, 22'd5000, 24'd5000, 1'b0, 48'(1000 + 10*k), '0));
      offer_word(mk_req(CmdReflect, '0, '0, 1'b0, 48'(1005 + 10*k), 31'd9999));
    end
    offer_word(mk_req(CmdSelect, 22'd5000, 24'd5000, 1'b0, 48'd1100, '0));
    offer_word(mk_req(CmdSelect, 22'd5000, 24'd5000, 1'b0, 48'd2000, '0));
  endtask

  // Several register settings, each followed by bursty random traffic.
  task automatic test_random_phases();
    for (int p = 0; p < 7; p++) begin
      settle_outstanding();
      load_setup(p);
      run_sleep_traffic(48);
    end
  endtask

  // Back-to-back traffic with neither side idling.
  task automatic test_steady_tail();
    settle_outstanding();
    bursty = 1'b0;
    load_setup(int'($urandom_range(4, 9)));
    run_sleep_traffic(40);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdSelect;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_setup();
    test_bus_master_holdoff();
    test_break_demotion();
    test_random_phases();
    test_steady_tail();
    settle_outstanding();
    repeat (16) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
